// File: design/bal_pkg.sv
// Package for the bounded array list engine: sizes, codes and payload types.
`default_nettype none
package bal_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_GET    = 3'd0;
   localparam logic [OP_W-1:0] OP_SET    = 3'd1;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       count;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   // Broadcast to every cell; flags are already qualified by request accept and success.
   typedef struct packed {
      logic                     do_set;
      logic                     do_append;
      logic                     do_insert;
      logic                     do_remove;
      logic [POS_W-1:0]         position;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: design/bal_cell.sv
// One storage cell of the list: holds one element and shifts with its neighbors.
`default_nettype none
module bal_cell (
   input  wire logic                              clock,
   input  wire bal_pkg::cell_cmd_type             cmd,
   input  wire logic [bal_pkg::POS_W-1:0]         cell_index,
   input  wire logic signed [bal_pkg::DATA_W-1:0] lower_data,
   input  wire logic signed [bal_pkg::DATA_W-1:0] upper_data,
   output logic signed [bal_pkg::DATA_W-1:0]      data
);

   logic signed [bal_pkg::DATA_W-1:0] data_ff;
   logic signed [bal_pkg::DATA_W-1:0] data_in;
   logic [bal_pkg::COUNT_W-1:0]       index_ext;

   assign index_ext = bal_pkg::COUNT_W'(cell_index);

   always_comb begin
      data_in = data_ff;
      if (cmd.do_set && cell_index == cmd.position) begin
         data_in = cmd.value;
      end
      if (cmd.do_append && index_ext == cmd.count) begin
         data_in = cmd.value;
      end
      if (cmd.do_insert) begin
         if (cell_index == cmd.position) begin
            data_in = cmd.value;
         end else if (cell_index > cmd.position && index_ext <= cmd.count) begin
            data_in = lower_data;
         end
      end
      if (cmd.do_remove && cell_index >= cmd.position &&
          (index_ext + bal_pkg::COUNT_W'(1)) < cmd.count) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// File: design/bounded_array_list_engine.sv
// Top level of the bounded array list engine: count, status, cell row and result register.
`default_nettype none
// The list lives in a row of 16 register cells that all shift in the same cycle, so
// every operation (get, set, append, insert, remove, clear) finishes in the cycle it
// is accepted and its result appears in the output register on the next edge. One
// request is taken per clock whenever the output register is empty or being drained
// in that cycle; the rate is set by the cell update and the result register.
module bounded_array_list_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bal_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bal_pkg::rsp_type      rsp_payload
);

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   bal_pkg::rsp_type              rsp_ff;
   bal_pkg::rsp_type              rsp_in;
   logic [bal_pkg::COUNT_W-1:0]   count_ff;
   logic [bal_pkg::COUNT_W-1:0]   count_in;
   logic                          req_fire;
   logic                          in_range;
   logic                          full;
   bal_pkg::cell_cmd_type         cmd;
   logic signed [bal_pkg::DATA_W-1:0] cell_data [bal_pkg::CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign in_range  = bal_pkg::COUNT_W'(req_payload.position) < count_ff;
   assign full      = count_ff >= bal_pkg::COUNT_W'(bal_pkg::CAPACITY);

   always_comb begin
      cmd           = '0;
      cmd.position  = req_payload.position;
      cmd.count     = count_ff;
      cmd.value     = req_payload.value;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      if (req_fire) begin
         rsp_in.read_value = '0;
         rsp_in.status     = bal_pkg::ST_OK;
         case (req_payload.opcode)
            bal_pkg::OP_GET: begin
               if (in_range) begin
                  rsp_in.read_value = cell_data[req_payload.position];
               end else begin
                  rsp_in.status = bal_pkg::ST_RANGE;
               end
            end
            bal_pkg::OP_SET: begin
               if (in_range) begin
                  cmd.do_set = 1'b1;
               end else begin
                  rsp_in.status = bal_pkg::ST_RANGE;
               end
            end
            bal_pkg::OP_APPEND: begin
               if (full) begin
                  rsp_in.status = bal_pkg::ST_FULL;
               end else begin
                  cmd.do_append = 1'b1;
                  count_in      = count_ff + bal_pkg::COUNT_W'(1);
               end
            end
            bal_pkg::OP_INSERT: begin
               if (!in_range) begin
                  rsp_in.status = bal_pkg::ST_RANGE;
               end else if (full) begin
                  rsp_in.status = bal_pkg::ST_FULL;
               end else begin
                  cmd.do_insert = 1'b1;
                  count_in      = count_ff + bal_pkg::COUNT_W'(1);
               end
            end
            bal_pkg::OP_REMOVE: begin
               if (in_range) begin
                  rsp_in.read_value = cell_data[req_payload.position];
                  cmd.do_remove     = 1'b1;
                  count_in          = count_ff - bal_pkg::COUNT_W'(1);
               end else begin
                  rsp_in.status = bal_pkg::ST_RANGE;
               end
            end
            bal_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         rsp_in.count = count_in;
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   genvar gi;
   generate
      for (gi = 0; gi < bal_pkg::CAPACITY; gi++) begin : g_cell
         localparam int LO = (gi == 0) ? 0 : gi - 1;
         localparam int HI = (gi == bal_pkg::CAPACITY - 1) ? gi : gi + 1;
         bal_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_index (bal_pkg::POS_W'(gi)),
            .lower_data (cell_data[LO]),
            .upper_data (cell_data[HI]),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bal_pkg::COUNT_W'(bal_pkg::CAPACITY))
      else $error("live count above capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && rsp_ff.count == count_ff)
      else $error("result count differs from live count");

   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.opcode == bal_pkg::OP_APPEND && !full
      |=> count_ff == $past(count_ff) + bal_pkg::COUNT_W'(1))
      else $error("append did not grow the list");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == bal_pkg::ST_FULL
      |-> rsp_ff.count == bal_pkg::COUNT_W'(bal_pkg::CAPACITY))
      else $error("full status with spare room");
`endif

endmodule
`default_nettype wire
